FILE: sv/prpw_pkg.sv
// ----------------------------------------------------------------------------
// prpw_pkg
// Shared types, constants and helpers for the pixel rotate and pack writer.
// ----------------------------------------------------------------------------
package prpw_pkg;

    // Largest frame dimension in pixels; counters and mapped coordinates are sized from it
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = $clog2(MAX_DIM);

    // Fixed field widths of the register set and the payload
    localparam int CFG_DIM_W  = 13;
    localparam int ROT_W      = 2;
    localparam int STRIDE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PIX_W      = 32;
    localparam int ADDR_W     = 28;
    localparam int PROD_W     = DIM_W + STRIDE_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_ROTATION   = 2'd2,
        CFG_ROW_STRIDE = 2'd3
    } cfg_idx_t;

    // Quarter-turn codes
    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] src_width;
        logic [CFG_DIM_W-1:0] src_height;
        rot_t                 rotation;
        logic [STRIDE_W-1:0]  row_stride;
    } cfg_t;

    // Output of the mapping stage
    typedef struct packed {
        logic [DIM_W-1:0] dx;
        logic [DIM_W-1:0] dy;
        logic [PIX_W-1:0] rgba;
        logic             last;
    } map_item_t;

    // Output of the multiply stage
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [DIM_W-1:0]  dx;
        logic [PIX_W-1:0]  rgba;
        logic              last;
    } prod_item_t;

    // Last valid index of a dimension: zero counts as one, oversize clamps to MAX_DIM - 1
    function automatic logic [DIM_W-1:0] last_index(input logic [CFG_DIM_W-1:0] dim);
        logic [DIM_W-1:0] res;
        if (dim == '0)
            res = '0;
        else if (32'(dim) > 32'(MAX_DIM))
            res = DIM_W'(MAX_DIM - 1);
        else
            res = DIM_W'(32'(dim) - 32'd1);
        return res;
    endfunction

    // ARGB to R,G,B,A memory byte order
    function automatic logic [PIX_W-1:0] argb_to_rgba(input logic [PIX_W-1:0] p);
        return {p[31:24], p[7:0], p[15:8], p[23:16]};
    endfunction

endpackage

FILE: sv/pixel_rotate_pack_writer_top.sv
// ----------------------------------------------------------------------------
// pixel_rotate_pack_writer_top
// Quarter-turn rotation writer: maps raster ARGB pixels to destination byte
// addresses and repacks them into R,G,B,A memory order.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------
//  pixel     pixel_valid/pixel_stall pixel_argb
//  result    result_valid/result_st. byte_address, rgba_word, frame_end
//  cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  One pixel per clock sustained while result_stall is low. A pixel passes
//  three registers (map, multiply, result) before its result is valid.
//  The 12x16 row multiply sets the middle stage; the column add follows it.
//  Reset clears the raster counters and all stage valids and loads the
//  register defaults (64x64, no rotation, 256-byte stride).
//  A result stall fills empty stages first, then raises pixel_stall; cfg_ready is high.
//
module pixel_rotate_pack_writer_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [prpw_pkg::PIX_W-1:0]        pixel_argb,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [prpw_pkg::ADDR_W-1:0]       byte_address,
    output logic [prpw_pkg::PIX_W-1:0]        rgba_word,
    output logic                              frame_end,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prpw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prpw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    prpw_pkg::cfg_t      cfg_reg;
    prpw_pkg::cfg_t      cfg_next;
    logic                map_valid;
    logic                map_stall;
    prpw_pkg::map_item_t map_item;

    assign cfg_ready = 1'b1;

    // Decode a register write; fields take the low bits of the data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (prpw_pkg::cfg_idx_t'(cfg_index))
                prpw_pkg::CFG_SRC_WIDTH:
                    cfg_next.src_width  = cfg_data[prpw_pkg::CFG_DIM_W-1:0];
                prpw_pkg::CFG_SRC_HEIGHT:
                    cfg_next.src_height = cfg_data[prpw_pkg::CFG_DIM_W-1:0];
                prpw_pkg::CFG_ROTATION:
                    cfg_next.rotation   = prpw_pkg::rot_t'(cfg_data[prpw_pkg::ROT_W-1:0]);
                prpw_pkg::CFG_ROW_STRIDE:
                    cfg_next.row_stride = cfg_data[prpw_pkg::STRIDE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= prpw_pkg::CFG_DIM_W'(64);
            cfg_reg.src_height <= prpw_pkg::CFG_DIM_W'(64);
            cfg_reg.rotation   <= prpw_pkg::ROT_0;
            cfg_reg.row_stride <= prpw_pkg::STRIDE_W'(256);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Stage 1: raster position and rotated coordinates
    prpw_map u_map
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_argb  (pixel_argb),
        .map_valid   (map_valid),
        .map_stall   (map_stall),
        .map_item    (map_item)
    );

    // Stages 2 and 3: row multiply, column add, result register
    prpw_addr u_addr
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_stride   (cfg_reg.row_stride),
        .map_valid    (map_valid),
        .map_stall    (map_stall),
        .map_item     (map_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .byte_address (byte_address),
        .rgba_word    (rgba_word),
        .frame_end    (frame_end)
    );

endmodule

FILE: sv/prpw_map.sv
// ----------------------------------------------------------------------------
// prpw_map
// Raster counters and quarter-turn coordinate mapping, one registered stage.
// ----------------------------------------------------------------------------
module prpw_map
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  prpw_pkg::cfg_t                cfg,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic [prpw_pkg::PIX_W-1:0]    pixel_argb,
    output logic                          map_valid,
    input  logic                          map_stall,
    output prpw_pkg::map_item_t           map_item
);

    logic [prpw_pkg::DIM_W-1:0] col_reg;
    logic [prpw_pkg::DIM_W-1:0] col_next;
    logic [prpw_pkg::DIM_W-1:0] row_reg;
    logic [prpw_pkg::DIM_W-1:0] row_next;
    logic                       valid_reg;
    logic                       valid_next;
    prpw_pkg::map_item_t        item_reg;
    prpw_pkg::map_item_t        item_next;

    logic [prpw_pkg::DIM_W-1:0] w_last;
    logic [prpw_pkg::DIM_W-1:0] h_last;
    logic [prpw_pkg::DIM_W-1:0] x;
    logic [prpw_pkg::DIM_W-1:0] y;
    logic                       last_col;
    logic                       last_row;
    logic                       load;
    logic                       accept;

    assign load        = !(valid_reg && map_stall);
    assign accept      = pixel_valid && load;
    assign pixel_stall = !load;

    assign w_last   = prpw_pkg::last_index(cfg.src_width);
    assign h_last   = prpw_pkg::last_index(cfg.src_height);
    assign last_col = (col_reg >= w_last);
    assign last_row = (row_reg >= h_last);
    assign x        = last_col ? w_last : col_reg;
    assign y        = last_row ? h_last : row_reg;

    always_comb
    begin
        item_next.rgba = prpw_pkg::argb_to_rgba(pixel_argb);
        item_next.last = last_col && last_row;
        case (cfg.rotation)
            prpw_pkg::ROT_90:
            begin
                item_next.dx = h_last - y;
                item_next.dy = x;
            end
            prpw_pkg::ROT_180:
            begin
                item_next.dx = w_last - x;
                item_next.dy = h_last - y;
            end
            prpw_pkg::ROT_270:
            begin
                item_next.dx = y;
                item_next.dy = w_last - x;
            end
            default:
            begin
                item_next.dx = x;
                item_next.dy = y;
            end
        endcase
    end

    // Advance the raster position; wrap at row and frame end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign valid_next = load ? pixel_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign map_valid = valid_reg;
    assign map_item  = item_reg;

`ifndef ASSERT_OFF
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col |=> col_reg == '0)
        else $error("column counter did not wrap at row end");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_col |=> col_reg == $past(col_reg) + 1'b1 && $stable(row_reg))
        else $error("column counter did not step inside a row");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(col_reg) && $stable(row_reg))
        else $error("raster position moved without a transaction");
`endif

endmodule

FILE: sv/prpw_addr.sv
// ----------------------------------------------------------------------------
// prpw_addr
// Destination byte address: registered row multiply, then column add.
// ----------------------------------------------------------------------------
module prpw_addr
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [prpw_pkg::STRIDE_W-1:0]   row_stride,
    input  logic                            map_valid,
    output logic                            map_stall,
    input  prpw_pkg::map_item_t             map_item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [prpw_pkg::ADDR_W-1:0]     byte_address,
    output logic [prpw_pkg::PIX_W-1:0]      rgba_word,
    output logic                            frame_end
);

    logic                        mul_valid_reg;
    logic                        mul_valid_next;
    prpw_pkg::prod_item_t        mul_reg;
    prpw_pkg::prod_item_t        mul_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [prpw_pkg::ADDR_W-1:0] addr_reg;
    logic [prpw_pkg::ADDR_W-1:0] addr_next;
    logic [prpw_pkg::PIX_W-1:0]  rgba_reg;
    logic                        last_reg;
    logic                        out_load;
    logic                        mul_load;
    logic                        mul_stall;

    assign out_load  = !(out_valid_reg && result_stall);
    assign mul_stall = !out_load;
    assign mul_load  = !(mul_valid_reg && mul_stall);
    assign map_stall = !mul_load;

    // Full-width product: both operands widened before the multiply
    always_comb
    begin
        mul_next.prod = prpw_pkg::PROD_W'(map_item.dy) * prpw_pkg::PROD_W'(row_stride);
        mul_next.dx   = map_item.dx;
        mul_next.rgba = map_item.rgba;
        mul_next.last = map_item.last;
    end

    // Keep only the low address bits on overflow
    assign addr_next = prpw_pkg::ADDR_W'(
        (prpw_pkg::ADDR_W+1)'(mul_reg.prod) + (prpw_pkg::ADDR_W+1)'({mul_reg.dx, 2'b00}));

    assign mul_valid_next = mul_load ? map_valid : mul_valid_reg;
    assign out_valid_next = out_load ? mul_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load && map_valid)
        begin
            mul_reg <= mul_next;
        end
        if (out_load && mul_valid_reg)
        begin
            addr_reg <= addr_next;
            rgba_reg <= mul_reg.rgba;
            last_reg <= mul_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign byte_address = addr_reg;
    assign rgba_word    = rgba_reg;
    assign frame_end    = last_reg;

endmodule
